// File: hdl/vrts_pkg.sv
package vrts_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int DIR_FRAC       = 14;
  localparam int DIR_W          = 16;
  localparam int COORD_W        = 32;
  localparam int NUM_AXES       = 3;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FWD   = 2'd1;
  localparam logic [1:0] CMD_BACK  = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  // Control from the sequencer to each lane divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Lane status back to the sequencer.
  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

// File: hdl/voxel_ray_traversal_step.sv
// Voxel ray traversal step. Each input beat carries a command: start a ray,
// step forward or step back; each command yields exactly one output beat with
// the current point and the face normal (axis and sign) of the next crossing.
// A step forward or step back updates the state at the accepting edge, and the
// output register loads in the cycle after; the input is ready again in the
// cycle after the output beat is taken, so no new command is accepted until the
// last result beat has gone. A start runs three parallel restoring dividers, one
// per axis, that each produce one quotient bit a cycle for quotients of
// FRAC_BITS + 15 bits; once all lanes are done, the results load into the state
// registers as ST_OUT is entered and the output register loads from them. Zero
// direction components give an all-ones ("never") time. Command code 3 returns
// the current state unchanged.
module voxel_ray_traversal_step #(
  parameter int FRAC_BITS  = vrts_pkg::FRAC_BITS_DEF,
  parameter int TIME_WIDTH = vrts_pkg::TIME_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // From bit 0: command[1:0], start_x, start_y, start_z, dir_x, dir_y,
  // dir_z, then 6 zero bits.
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // From bit 0: point_x, point_y, point_z, normal_axis[1:0],
  // normal_negative, then 5 zero bits.
  output logic [103:0] out_tdata
);
  import vrts_pkg::*;

  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  state_t state_r, state_nxt;
  logic [TIME_WIDTH-1:0] cross_r [NUM_AXES];
  logic [TIME_WIDTH-1:0] delta_r [NUM_AXES];
  logic [COORD_W-1:0]    point_r [NUM_AXES];
  logic [NUM_AXES-1:0]   neg_r;
  logic [103:0]          obuf_r;
  logic                  ovalid_r;
  logic                  launch_r;

  logic [1:0]            cmd;
  logic                  acc;
  div_ctl_t              dctl;
  div_sts_t              dsts [NUM_AXES];
  logic [NUM_AXES-1:0]   lneg;
  logic [TIME_WIDTH-1:0] lcross [NUM_AXES];
  logic [TIME_WIDTH-1:0] ldelta [NUM_AXES];
  logic [1:0]            near_a, far_a;

  assign cmd        = in_tdata[1:0];
  assign in_tready  = state_r == ST_IDLE;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = obuf_r;
  assign dctl.start = acc && cmd == CMD_START;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    vrts_lane_div #(.FRAC_BITS(FRAC_BITS), .TIME_WIDTH(TIME_WIDTH)) u_div (
      .clk, .rst_n, .ctl(dctl),
      .start_bits(in_tdata[2+COORD_W*g +: COORD_W]),
      .dir_bits(in_tdata[2+COORD_W*NUM_AXES+DIR_W*g +: DIR_W]),
      .sts(dsts[g]), .neg(lneg[g]), .cross_q(lcross[g]), .delta_q(ldelta[g])
    );
  end

  vrts_merge #(.TIME_WIDTH(TIME_WIDTH)) u_merge (
    .t0(cross_r[0]), .t1(cross_r[1]), .t2(cross_r[2]),
    .near_axis(near_a), .far_axis(far_a)
  );

  // State update for one step on the chosen axis.
  logic [1:0]            sax;
  logic                  fwd, up;
  logic [TIME_WIDTH:0]   tsum;
  logic [TIME_WIDTH-1:0] tnew;
  logic [COORD_W-1:0]    pnew;
  localparam logic [COORD_W-1:0] ONE_CELL = COORD_W'(1) << FRAC_BITS;

  always_comb begin
    fwd  = cmd == CMD_FWD;
    sax  = fwd ? near_a : far_a;
    up   = (neg_r[sax] == 1'b0) == fwd;
    pnew = up ? point_r[sax] + ONE_CELL : point_r[sax] - ONE_CELL;
    if (fwd) begin
      tsum = {1'b0, cross_r[sax]} + {1'b0, delta_r[sax]};
      tnew = tsum[TIME_WIDTH] ? TMAX : tsum[TIME_WIDTH-1:0];
    end else begin
      tsum = '0;
      tnew = (cross_r[sax] < delta_r[sax]) ? '0 : cross_r[sax] - delta_r[sax];
    end
    if (cross_r[sax] == TMAX) tnew = TMAX;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) state_nxt = (cmd == CMD_START) ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (!launch_r && dsts[0].done && dsts[1].done && dsts[2].done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Stay until the result beat has been taken.
        if (ovalid_r && out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      launch_r <= 1'b0;
      neg_r    <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        cross_r[i] <= TMAX;
        delta_r[i] <= TMAX;
        point_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      launch_r <= dctl.start;
      // The result is formed on the first cycle in ST_OUT, after the state lands.
      if (ovalid_r && out_tready) begin
        ovalid_r <= 1'b0;
      end else if (state_r == ST_OUT && !ovalid_r) begin
        ovalid_r <= 1'b1;
      end
      if (acc && (cmd == CMD_FWD || cmd == CMD_BACK)) begin
        point_r[sax] <= pnew;
        cross_r[sax] <= tnew;
      end
      if (acc && cmd == CMD_START) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          point_r[i] <= in_tdata[2+COORD_W*i +: COORD_W];
        end
      end
      if (state_r == ST_DIV && state_nxt == ST_OUT) begin
        neg_r <= lneg;
        for (int i = 0; i < NUM_AXES; i++) begin
          cross_r[i] <= lcross[i];
          delta_r[i] <= ldelta[i];
        end
      end
    end
  end

  // Output register loads on the first cycle in ST_OUT.
  logic out_load;
  assign out_load = state_r == ST_OUT && !ovalid_r;
  always_ff @(posedge clk) begin
    if (out_load) begin
      obuf_r <= {5'b0, neg_r[near_a], near_a, point_r[2], point_r[1], point_r[0]};
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready) else $error("ready while busy");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> state_r == ST_OUT) else $error("result outside output state");
  a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.start |=> state_r == ST_DIV) else $error("start did not enter division");
`endif

endmodule

// File: hdl/vrts_lane_div.sv
// One lane: restoring divider computing the crossing time and the delta time
// of one axis, one quotient bit per cycle for both quotients together.
module vrts_lane_div #(
  parameter int FRAC_BITS  = vrts_pkg::FRAC_BITS_DEF,
  parameter int TIME_WIDTH = vrts_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vrts_pkg::div_ctl_t                ctl,
  input  logic [vrts_pkg::COORD_W-1:0]      start_bits,
  input  logic [vrts_pkg::DIR_W-1:0]        dir_bits,
  output vrts_pkg::div_sts_t                sts,
  output logic                              neg,
  output logic [TIME_WIDTH-1:0]             cross_q,
  output logic [TIME_WIDTH-1:0]             delta_q
);
  import vrts_pkg::*;

  localparam int NUM_W = FRAC_BITS + 1 + DIR_FRAC;   // dividend width
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int REM_W = DIR_W + 1;
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  logic [NUM_W-1:0] num_c_r, num_c_nxt, num_d_r, num_d_nxt;
  logic [REM_W-1:0] rem_c_r, rem_c_nxt, rem_d_r, rem_d_nxt;
  logic [NUM_W-1:0] quo_c_r, quo_c_nxt, quo_d_r, quo_d_nxt;
  logic [DIR_W-1:0] mag_r, mag_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, neg_r, neg_nxt;

  logic [FRAC_BITS-1:0] frac;
  logic [FRAC_BITS:0]   bdist;
  logic [DIR_W-1:0]     mag_in;
  logic                 dneg;
  logic [REM_W-1:0]     sc, sd;

  assign frac   = start_bits[FRAC_BITS-1:0];
  assign dneg   = dir_bits[DIR_W-1];
  assign mag_in = dneg ? (~dir_bits + 1'b1) : dir_bits;
  assign bdist  = dneg ? {1'b0, frac} : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac});
  assign sc     = {rem_c_r[REM_W-2:0], num_c_r[NUM_W-1]};
  assign sd     = {rem_d_r[REM_W-2:0], num_d_r[NUM_W-1]};

  always_comb begin
    num_c_nxt = num_c_r;
    num_d_nxt = num_d_r;
    rem_c_nxt = rem_c_r;
    rem_d_nxt = rem_d_r;
    quo_c_nxt = quo_c_r;
    quo_d_nxt = quo_d_r;
    mag_nxt   = mag_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    neg_nxt   = neg_r;
    if (ctl.start) begin
      num_c_nxt = {bdist, {DIR_FRAC{1'b0}}};
      num_d_nxt = {1'b1, {(NUM_W-1){1'b0}}};
      rem_c_nxt = '0;
      rem_d_nxt = '0;
      quo_c_nxt = '0;
      quo_d_nxt = '0;
      mag_nxt   = mag_in;
      neg_nxt   = dneg;
      cnt_nxt   = CNT_W'(NUM_W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      num_c_nxt = num_c_r << 1;
      num_d_nxt = num_d_r << 1;
      if (sc >= {1'b0, mag_r}) begin
        rem_c_nxt = sc - {1'b0, mag_r};
        quo_c_nxt = {quo_c_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_c_nxt = sc;
        quo_c_nxt = {quo_c_r[NUM_W-2:0], 1'b0};
      end
      if (sd >= {1'b0, mag_r}) begin
        rem_d_nxt = sd - {1'b0, mag_r};
        quo_d_nxt = {quo_d_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_d_nxt = sd;
        quo_d_nxt = {quo_d_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_c_r <= num_c_nxt;
    num_d_r <= num_d_nxt;
    rem_c_r <= rem_c_nxt;
    rem_d_r <= rem_d_nxt;
    quo_c_r <= quo_c_nxt;
    quo_d_r <= quo_d_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
  end

  function automatic logic [TIME_WIDTH-1:0] sat(input logic [NUM_W-1:0] q);
    logic [NUM_W+TIME_WIDTH-1:0] qw;
    qw = {{TIME_WIDTH{1'b0}}, q};
    if (qw > {{NUM_W{1'b0}}, TMAX}) sat = TMAX;
    else                            sat = qw[TIME_WIDTH-1:0];
  endfunction

  assign sts.done = !busy_r;
  assign neg      = neg_r;
  assign cross_q  = (mag_r == '0) ? TMAX : sat(quo_c_r);
  assign delta_q  = (mag_r == '0) ? TMAX : sat(quo_d_r);

endmodule

// File: hdl/vrts_merge.sv
// Merging stage: picks the nearest and farthest axes over the three lanes.
module vrts_merge #(
  parameter int TIME_WIDTH = vrts_pkg::TIME_WIDTH_DEF
) (
  input  logic [TIME_WIDTH-1:0] t0,
  input  logic [TIME_WIDTH-1:0] t1,
  input  logic [TIME_WIDTH-1:0] t2,
  output logic [1:0]            near_axis,
  output logic [1:0]            far_axis
);
  import vrts_pkg::*;

  always_comb begin
    if (t0 < t1) near_axis = (t0 < t2) ? AXIS_X : AXIS_Z;
    else         near_axis = (t1 < t2) ? AXIS_Y : AXIS_Z;
    if (t0 > t1) far_axis  = (t0 > t2) ? AXIS_X : AXIS_Z;
    else         far_axis  = (t1 > t2) ? AXIS_Y : AXIS_Z;
  end

endmodule

// File: sim/voxel_ray_traversal_step_test.sv
module voxel_ray_traversal_step_test;
  import vrts_pkg::*;

  // The block under test runs at its default sizes: Q16.16 points and
  // 32-bit unsigned crossing times with 16 fraction bits.
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int TW = TIME_WIDTH_DEF;
  localparam logic [TW-1:0] NEVER = {TW{1'b1}};
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [151:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;

  voxel_ray_traversal_step uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [1:0]  axis;
    logic        neg;
  } voxel_result_t;

  // Shadow state of the ray walker, kept at the block's own widths.
  logic          sh_neg   [3];
  logic [TW-1:0] sh_cross [3];
  logic [TW-1:0] sh_delta [3];
  logic [31:0]   sh_point [3];

  voxel_result_t expected_voxels[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned starts_sent = 0;
  int unsigned steps_sent = 0;

  // The clock runs with a 12-unit period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Run guard: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [TW-1:0] sat_time(logic [63:0] v);
    return (v > {32'd0, NEVER}) ? NEVER : v[TW-1:0];
  endfunction

  function automatic logic [1:0] nearest_axis();
    if (sh_cross[0] < sh_cross[1]) return (sh_cross[0] < sh_cross[2]) ? AXIS_X : AXIS_Z;
    return (sh_cross[1] < sh_cross[2]) ? AXIS_Y : AXIS_Z;
  endfunction

  function automatic logic [1:0] farthest_axis();
    if (sh_cross[0] > sh_cross[1]) return (sh_cross[0] > sh_cross[2]) ? AXIS_X : AXIS_Z;
    return (sh_cross[1] > sh_cross[2]) ? AXIS_Y : AXIS_Z;
  endfunction

  // Moves the shadow walker by one command and returns the beat it must give.
  function automatic voxel_result_t walk_voxel(logic [1:0] cmd, logic [31:0] s[3],
                                               logic [15:0] d[3]);
    voxel_result_t r;
    logic [63:0] frac, mag, bdist;
    logic [1:0] a;
    logic up;
    if (cmd == CMD_START) begin
      for (int i = 0; i < 3; i++) begin
        frac = {32'd0, s[i]} & ((64'd1 << FRAC) - 1);
        mag = d[i][15] ? (64'h10000 - d[i]) : {48'd0, d[i]};
        bdist = d[i][15] ? frac : ((64'd1 << FRAC) - frac);
        sh_neg[i] = d[i][15];
        sh_point[i] = s[i];
        if (mag == 0) begin
          sh_cross[i] = NEVER;
          sh_delta[i] = NEVER;
        end else begin
          sh_cross[i] = sat_time((bdist << DIR_FRAC) / mag);
          sh_delta[i] = sat_time(((64'd1 << FRAC) << DIR_FRAC) / mag);
        end
      end
    end else if (cmd == CMD_FWD || cmd == CMD_BACK) begin
      a = (cmd == CMD_FWD) ? nearest_axis() : farthest_axis();
      up = (sh_neg[a] == 1'b0) == (cmd == CMD_FWD);
      sh_point[a] = up ? sh_point[a] + (32'd1 << FRAC) : sh_point[a] - (32'd1 << FRAC);
      if (sh_cross[a] != NEVER) begin
        if (cmd == CMD_FWD)
          sh_cross[a] = sat_time({32'd0, sh_cross[a]} + {32'd0, sh_delta[a]});
        else
          sh_cross[a] = (sh_cross[a] < sh_delta[a]) ? '0 : sh_cross[a] - sh_delta[a];
      end
    end
    a = nearest_axis();
    r.px = sh_point[0];
    r.py = sh_point[1];
    r.pz = sh_point[2];
    r.axis = a;
    r.neg = sh_neg[a];
    return r;
  endfunction

  // Sends one command beat and records what the block must answer. Valid stays
  // high after the beat is taken; a gap in the next call or the drain lowers it.
  task automatic send_command(logic [1:0] cmd, logic [31:0] sx, logic [31:0] sy,
                              logic [31:0] sz, logic [15:0] dx, logic [15:0] dy,
                              logic [15:0] dz);
    logic [31:0] s[3];
    logic [15:0] d[3];
    s[0] = sx; s[1] = sy; s[2] = sz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, dz, dy, dx, sz, sy, sx, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_voxels.push_back(walk_voxel(cmd, s, d));
    if (cmd == CMD_START) starts_sent++;
    else steps_sent++;
  endtask

  task automatic send_step(logic [1:0] cmd);
    send_command(cmd, $urandom, $urandom, $urandom,
                 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Receiver side: random backpressure plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Result checker: every output beat is matched against the oldest prediction.
  always @(posedge clk) begin
    voxel_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
             out_tdata[97:96], out_tdata[98]};
      results_seen <= results_seen + 1;
      if (expected_voxels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected output beat %h", out_tdata);
      end else begin
        want = expected_voxels.pop_front();
        if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
            got.axis !== want.axis || got.neg !== want.neg) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("beat %0d: expected p=(%h %h %h) axis %0d neg %0d, got p=(%h %h %h) axis %0d neg %0d",
                     results_seen, want.px, want.py, want.pz, want.axis, want.neg,
                     got.px, got.py, got.pz, got.axis, got.neg);
        end
      end
    end
  end

  // Extremes of origin and direction, zero directions, every command code.
  task automatic test_directed();
    send_step(CMD_FWD);
    send_step(CMD_BACK);
    send_command(CMD_START, 32'h0000_8000, 32'h0001_4000, 32'h0002_0000,
                 16'h4000, 16'hC000, 16'h2000);
    repeat (3) send_step(CMD_FWD);
    repeat (2) send_step(CMD_BACK);
    send_step(CMD_NOP);
    // Zero direction on every axis: all times stay never, ties go to z.
    send_command(CMD_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h0, 16'h0, 16'h0);
    send_step(CMD_FWD);
    send_step(CMD_BACK);
    // Smallest magnitudes give the largest times; the most negative direction is sent too.
    send_command(CMD_START, 32'h7FFF_0000, 32'h8000_FFFF, 32'hFFFF_FFFF,
                 16'h0001, 16'hFFFF, 16'h8000);
    repeat (2) send_step(CMD_FWD);
    repeat (3) send_step(CMD_BACK);
    // Equal directions force ties; the point wraps near the top of the range.
    send_command(CMD_START, 32'h7FFF_8000, 32'h7FFF_8000, 32'h7FFF_8000,
                 16'h7FFF, 16'h7FFF, 16'h7FFF);
    repeat (4) send_step(CMD_FWD);
    send_step(CMD_BACK);
    send_step(CMD_NOP);
  endtask

  // Random rays, each followed by a walk of steps mostly forward; a few
  // beats are no-op commands.
  task automatic test_random_walks(int unsigned n_items);
    int unsigned sent;
    logic [15:0] d[3];
    sent = 0;
    while (sent < n_items) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(5))
          0: d[i] = 16'h0;
          1: d[i] = 16'($urandom_range(1, 16));
          2: d[i] = 16'h8000;
          default: d[i] = 16'($urandom);
        endcase
      end
      send_command(CMD_START, $urandom, $urandom, $urandom, d[0], d[1], d[2]);
      sent++;
      repeat ($urandom_range(4, 30)) begin
        case ($urandom_range(9))
          0, 1, 2: send_step(CMD_BACK);
          3: send_step(CMD_NOP);
          default: send_step(CMD_FWD);
        endcase
        sent++;
      end
    end
  endtask

  // The receiver stalls long enough for the block to fill and stop taking beats.
  task automatic test_backpressure();
    hold_off_cycles = 400;
    repeat (60) send_step(CMD_FWD);
    send_command(CMD_START, $urandom, $urandom, $urandom,
                 16'($urandom), 16'($urandom), 16'($urandom));
    repeat (20) send_step(CMD_BACK);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_voxels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 6;
    recv_gap_pct = 70;
    test_directed();
    test_random_walks(400);
    send_gap_pct = 70;
    recv_gap_pct = 6;
    test_random_walks(400);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_walks(400);
    test_backpressure();
    drain();

    $display("covered %0d ray starts and %0d step commands, %0d output beats checked",
             starts_sent, steps_sent, results_seen);
    if (mismatch_count == 0 && expected_voxels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: voxel_ray_traversal_step.f
hdl/vrts_pkg.sv
hdl/vrts_lane_div.sv
hdl/vrts_merge.sv
hdl/voxel_ray_traversal_step.sv
sim/voxel_ray_traversal_step_test.sv
